/* rtl/triangle_circumcircle_defines.svh */
// Assertion macros for the triangle circumcircle block.
// Included by the top level; relies on clk and rst_n in the including module.
`ifndef TRIANGLE_CIRCUMCIRCLE_DEFINES_SVH
`define TRIANGLE_CIRCUMCIRCLE_DEFINES_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define TCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcc: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define TCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcc: next-cycle check failed");
`else
`define TCC_ASSERT_NOW(lbl, ante, cons)
`define TCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/tcc_pkg.sv */
// Shared constants and types for the triangle circumcircle pipeline.
// No dependencies.
package tcc_pkg;

    // Register stages of the front end (differences, products, numerators).
    localparam int FRONT_STAGES = 6;
    // Divider stages besides one per quotient bit: magnitude, range check, rounding.
    localparam int DIV_EXTRA_STAGES = 3;
    // Stages between divider and square root: clamp, squares, sum.
    localparam int POST_STAGES = 3;

    // Flags that travel beside the radius computation.
    typedef struct packed {
        logic sat;
        logic big;
        logic degen;
    } tcc_flags_t;

endpackage

/* rtl/tcc_in_if.sv */
// Input channel carrying one triangle word: three vertices.
// Depends on nothing.
interface tcc_in_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by_coord;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;

    modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
    modport sink (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface

/* rtl/tcc_out_if.sv */
// Output channel carrying one circle word: centre, radius and flags.
// Depends on nothing.
interface tcc_out_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] center_x;
    logic signed [COORD_WIDTH-1:0] center_y;
    logic        [COORD_WIDTH-1:0] radius;
    logic                          degenerate;
    logic                          saturated;

    modport source (output valid, center_x, center_y, radius, degenerate, saturated,
                    input ready);
    modport sink (input valid, center_x, center_y, radius, degenerate, saturated,
                  output ready);
endinterface

/* rtl/triangle_circumcircle.sv */
// Circumscribed circle of a triangle: top level and output stage.
// Depends on tcc_pkg, tcc_in_if, tcc_out_if, tcc_front, tcc_divider, tcc_sqrt
// and triangle_circumcircle_defines.svh.
//
// Usage: a triangle word (three signed fixed-point vertices) enters on the
// vertices channel; one circle word leaves on the circle channel for each
// one, in order. The centre is rounded to nearest, the radius is the rounded
// distance from the first vertex; values that do not fit clamp and set
// saturated. Collinear vertices give zeros with degenerate set.
// Throughput: one word per cycle while the receiver takes results. The
// pipeline is six front-end stages, the divider (one quotient bit
// per stage plus three), three stages into the square root (one root bit
// per stage) and the output register.
// The whole pipeline moves as one: while the receiver holds off a waiting
// result, every stage holds and vertices.ready is low, even when inner
// stages are empty. Reset clears the valid bits only; no word is in flight
// after.
`include "triangle_circumcircle_defines.svh"
module triangle_circumcircle #(
    parameter int COORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    tcc_in_if.sink    vertices,
    tcc_out_if.source circle
);
    import tcc_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int QB      = W + 2;
    localparam int DIV_LAT = QB + DIV_EXTRA_STAGES;
    localparam int SQ_LAT  = W + 1;
    localparam int SIDE_A  = FRONT_STAGES + DIV_LAT;
    localparam int SIDE_P  = POST_STAGES + SQ_LAT - 1;
    localparam int N_STG   = SIDE_A + POST_STAGES + SQ_LAT + 1;

    logic advance;

    // Valid bits travel with the words; the last one is the output register.
    logic [N_STG-1:0] vld_reg;

    assign advance        = !vld_reg[N_STG-1] || circle.ready;
    assign vertices.ready = advance;
    assign circle.valid   = vld_reg[N_STG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[N_STG-2:0], vertices.valid};
        end
    end

    // Front end and the two dividers.
    logic signed [3*W+3:0] num_x, num_y;
    logic signed [2*W+3:0] den;
    logic                  degen_f;
    logic signed [W+3:0]   dx, dy;

    tcc_front #(.COORD_WIDTH(W)) u_front (
        .clk      (clk),
        .en       (advance),
        .ax       (vertices.ax),
        .ay       (vertices.ay),
        .bx       (vertices.bx),
        .by_coord (vertices.by_coord),
        .cx       (vertices.cx),
        .cy       (vertices.cy),
        .num_x    (num_x),
        .num_y    (num_y),
        .den      (den),
        .degen    (degen_f)
    );

    tcc_divider #(.COORD_WIDTH(W)) u_div_x (
        .clk  (clk),
        .en   (advance),
        .num  (num_x),
        .den  (den),
        .quot (dx)
    );

    tcc_divider #(.COORD_WIDTH(W)) u_div_y (
        .clk  (clk),
        .en   (advance),
        .num  (num_y),
        .den  (den),
        .quot (dy)
    );

    // First vertex and collinear flag delayed to meet the divider output.
    logic signed [W-1:0] ax_reg [SIDE_A];
    logic signed [W-1:0] ay_reg [SIDE_A];
    logic                dg_reg [DIV_LAT];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax_reg[0] <= vertices.ax;
            ay_reg[0] <= vertices.ay;
            dg_reg[0] <= degen_f;
        end
    end

    for (genvar i = 1; i < SIDE_A; i++)
    begin : g_side_a
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                ax_reg[i] <= ax_reg[i-1];
                ay_reg[i] <= ay_reg[i-1];
            end
        end
    end

    for (genvar i = 1; i < DIV_LAT; i++)
    begin : g_side_d
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                dg_reg[i] <= dg_reg[i-1];
            end
        end
    end

    // Centre: add the first vertex and clamp; offset magnitudes for the radius.
    logic signed [W+4:0] sx, sy;
    logic                inr_x, inr_y;
    logic [W+2:0]        mx, my;
    logic [W-1:0]        ox_next, oy_next;
    logic [W-1:0]        ox1_reg, oy1_reg;
    logic [W-1:0]        mx1_reg, my1_reg;
    tcc_flags_t          fl1_reg;

    assign sx    = {{5{ax_reg[SIDE_A-1][W-1]}}, ax_reg[SIDE_A-1]} + {dx[W+3], dx};
    assign sy    = {{5{ay_reg[SIDE_A-1][W-1]}}, ay_reg[SIDE_A-1]} + {dy[W+3], dy};
    assign inr_x = (&sx[W+4:W-1]) || !(|sx[W+4:W-1]);
    assign inr_y = (&sy[W+4:W-1]) || !(|sy[W+4:W-1]);
    assign mx    = dx[W+3] ? (W+3)'(-dx) : dx[W+2:0];
    assign my    = dy[W+3] ? (W+3)'(-dy) : dy[W+2:0];

    always_comb
    begin
        ox_next = sx[W-1:0];
        oy_next = sy[W-1:0];
        if (!inr_x)
        begin
            ox_next = sx[W+4] ? {1'b1, (W-1)'(0)} : {1'b0, {(W-1){1'b1}}};
        end
        if (!inr_y)
        begin
            oy_next = sy[W+4] ? {1'b1, (W-1)'(0)} : {1'b0, {(W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ox1_reg       <= ox_next;
            oy1_reg       <= oy_next;
            mx1_reg       <= mx[W-1:0];
            my1_reg       <= my[W-1:0];
            fl1_reg.sat   <= !inr_x || !inr_y;
            fl1_reg.big   <= (|mx[W+2:W]) || (|my[W+2:W]);
            fl1_reg.degen <= dg_reg[DIV_LAT-1];
        end
    end

    // Squared offsets, then their sum as the radicand.
    logic [2*W-1:0] sqx2_reg, sqy2_reg;
    logic [2*W:0]   n3_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sqx2_reg <= mx1_reg * mx1_reg;
            sqy2_reg <= my1_reg * my1_reg;
            n3_reg   <= {1'b0, sqx2_reg} + {1'b0, sqy2_reg};
        end
    end

    logic [W:0]   root;
    logic [W+1:0] rem;

    tcc_sqrt #(.COORD_WIDTH(W)) u_sqrt (
        .clk      (clk),
        .en       (advance),
        .radicand (n3_reg),
        .root     (root),
        .rem      (rem)
    );

    // Centre and flags delayed beside the square root.
    logic [W-1:0] sox_reg [SIDE_P];
    logic [W-1:0] soy_reg [SIDE_P];
    tcc_flags_t   sfl_reg [SIDE_P];

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sox_reg[0] <= ox1_reg;
            soy_reg[0] <= oy1_reg;
            sfl_reg[0] <= fl1_reg;
        end
    end

    for (genvar i = 1; i < SIDE_P; i++)
    begin : g_side_p
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                sox_reg[i] <= sox_reg[i-1];
                soy_reg[i] <= soy_reg[i-1];
                sfl_reg[i] <= sfl_reg[i-1];
            end
        end
    end

    // Output stage: round the root, clamp, and zero a degenerate word.
    tcc_flags_t   fl_o;
    logic [W+1:0] rad;
    logic         rad_sat;

    assign fl_o    = sfl_reg[SIDE_P-1];
    assign rad     = {1'b0, root} + (W+2)'(rem > {1'b0, root});
    assign rad_sat = fl_o.big || (|rad[W+1:W]);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (fl_o.degen)
            begin
                circle.center_x   <= '0;
                circle.center_y   <= '0;
                circle.radius     <= '0;
                circle.degenerate <= 1'b1;
                circle.saturated  <= 1'b0;
            end
            else
            begin
                circle.center_x   <= sox_reg[SIDE_P-1];
                circle.center_y   <= soy_reg[SIDE_P-1];
                circle.radius     <= rad_sat ? {W{1'b1}} : rad[W-1:0];
                circle.degenerate <= 1'b0;
                circle.saturated  <= fl_o.sat || rad_sat;
            end
        end
    end

    // A degenerate word carries zeros and no clamp.
    `TCC_ASSERT_NOW(a_degen_zero, circle.valid && circle.degenerate, circle.center_x == '0 && circle.center_y == '0 && circle.radius == '0 && !circle.saturated)
    // A held result freezes the pipeline input.
    `TCC_ASSERT_NOW(a_stall_blocks, circle.valid && !circle.ready, !vertices.ready)
    // An accepted word occupies the first stage next cycle.
    `TCC_ASSERT_NEXT(a_accept_fills, vertices.valid && vertices.ready, vld_reg[0])

endmodule

/* rtl/tcc_front.sv */
// Front end: vertex offsets, determinant and centre numerators in six stages.
// Depends on nothing beyond its ports.
module tcc_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [COORD_WIDTH-1:0]     ax,
    input  logic signed [COORD_WIDTH-1:0]     ay,
    input  logic signed [COORD_WIDTH-1:0]     bx,
    input  logic signed [COORD_WIDTH-1:0]     by_coord,
    input  logic signed [COORD_WIDTH-1:0]     cx,
    input  logic signed [COORD_WIDTH-1:0]     cy,
    output logic signed [3*COORD_WIDTH+3:0]   num_x,
    output logic signed [3*COORD_WIDTH+3:0]   num_y,
    output logic signed [2*COORD_WIDTH+3:0]   den,
    output logic                              degen
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * W + 2;
    localparam int DSW  = 2 * W + 4;
    localparam int NBW  = 2 * W + 2;
    localparam int PPW  = 2 * W + 3;
    localparam int NUMW = 3 * W + 4;

    // Stage 1: offsets of B and C from A.
    logic signed [DW-1:0] bx1_reg, by1_reg, qx1_reg, qy1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bx1_reg <= {bx[W-1], bx} - {ax[W-1], ax};
            by1_reg <= {by_coord[W-1], by_coord} - {ay[W-1], ay};
            qx1_reg <= {cx[W-1], cx} - {ax[W-1], ax};
            qy1_reg <= {cy[W-1], cy} - {ay[W-1], ay};
        end
    end

    // Stage 2: cross products and squares.
    logic signed [PW-1:0] pbq2_reg, pyq2_reg, bb2_reg, yy2_reg, xx2_reg, ww2_reg;
    logic signed [DW-1:0] bx2_reg, by2_reg, qx2_reg, qy2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pbq2_reg <= bx1_reg * qy1_reg;
            pyq2_reg <= by1_reg * qx1_reg;
            bb2_reg  <= bx1_reg * bx1_reg;
            yy2_reg  <= by1_reg * by1_reg;
            xx2_reg  <= qx1_reg * qx1_reg;
            ww2_reg  <= qy1_reg * qy1_reg;
            bx2_reg  <= bx1_reg;
            by2_reg  <= by1_reg;
            qx2_reg  <= qx1_reg;
            qy2_reg  <= qy1_reg;
        end
    end

    // Stage 3: four times the signed area and the squared norms of both offsets.
    logic [PW:0]           diff3;
    logic signed [DSW-1:0] d3_reg;
    logic [NBW-1:0]        nb3_reg, nq3_reg;
    logic signed [DW-1:0]  bx3_reg, by3_reg, qx3_reg, qy3_reg;

    assign diff3 = {pbq2_reg[PW-1], pbq2_reg} - {pyq2_reg[PW-1], pyq2_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_reg  <= {diff3, 1'b0};
            nb3_reg <= bb2_reg[NBW-1:0] + yy2_reg[NBW-1:0];
            nq3_reg <= xx2_reg[NBW-1:0] + ww2_reg[NBW-1:0];
            bx3_reg <= bx2_reg;
            by3_reg <= by2_reg;
            qx3_reg <= qx2_reg;
            qy3_reg <= qy2_reg;
        end
    end

    // Stage 4: partial products of offsets and norms, norms split in two halves.
    logic signed [PPW-1:0] qnb_lo_reg, qnb_hi_reg, bnq_lo_reg, bnq_hi_reg;
    logic signed [PPW-1:0] xnq_lo_reg, xnq_hi_reg, cnb_lo_reg, cnb_hi_reg;
    logic signed [DSW-1:0] d4_reg;
    logic signed [DW:0]    nb_lo, nb_hi, nq_lo, nq_hi;

    assign nb_lo = $signed({1'b0, nb3_reg[W:0]});
    assign nb_hi = $signed({1'b0, nb3_reg[NBW-1:W+1]});
    assign nq_lo = $signed({1'b0, nq3_reg[W:0]});
    assign nq_hi = $signed({1'b0, nq3_reg[NBW-1:W+1]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qnb_lo_reg <= qy3_reg * nb_lo;
            qnb_hi_reg <= qy3_reg * nb_hi;
            bnq_lo_reg <= by3_reg * nq_lo;
            bnq_hi_reg <= by3_reg * nq_hi;
            xnq_lo_reg <= bx3_reg * nq_lo;
            xnq_hi_reg <= bx3_reg * nq_hi;
            cnb_lo_reg <= qx3_reg * nb_lo;
            cnb_hi_reg <= qx3_reg * nb_hi;
            d4_reg     <= d3_reg;
        end
    end

    // Stage 5: recombine the partial products into full products.
    logic signed [NUMW-1:0] t_qnb_reg, t_bnq_reg, t_xnq_reg, t_cnb_reg;
    logic signed [DSW-1:0]  d5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_qnb_reg <= {qnb_hi_reg, (W+1)'(0)} + {{(W+1){qnb_lo_reg[PPW-1]}}, qnb_lo_reg};
            t_bnq_reg <= {bnq_hi_reg, (W+1)'(0)} + {{(W+1){bnq_lo_reg[PPW-1]}}, bnq_lo_reg};
            t_xnq_reg <= {xnq_hi_reg, (W+1)'(0)} + {{(W+1){xnq_lo_reg[PPW-1]}}, xnq_lo_reg};
            t_cnb_reg <= {cnb_hi_reg, (W+1)'(0)} + {{(W+1){cnb_lo_reg[PPW-1]}}, cnb_lo_reg};
            d5_reg    <= d4_reg;
        end
    end

    // Stage 6: centre numerators and the collinear check.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_x <= t_qnb_reg - t_bnq_reg;
            num_y <= t_xnq_reg - t_cnb_reg;
            den   <= d5_reg;
            degen <= (d5_reg == '0);
        end
    end

endmodule

/* rtl/tcc_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
// Depends on nothing beyond its ports.
module tcc_divider #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [3*COORD_WIDTH+3:0] num,
    input  logic signed [2*COORD_WIDTH+3:0] den,
    output logic signed [COORD_WIDTH+3:0]   quot
);

    localparam int W    = COORD_WIDTH;
    localparam int NUMW = 3 * W + 4;
    localparam int NMW  = 3 * W + 3;
    localparam int DSW  = 2 * W + 4;
    localparam int DMW  = 2 * W + 3;
    localparam int QB   = W + 2;
    localparam int RW   = W + 4;

    // Magnitudes and the quotient sign.
    logic [NMW-1:0] nmag_reg;
    logic [DMW-1:0] dmag_a_reg;
    logic           neg_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg   <= num[NUMW-1] ? NMW'(-num) : NMW'(num);
            dmag_a_reg <= den[DSW-1] ? DMW'(-den) : DMW'(den);
            neg_a_reg  <= num[NUMW-1] ^ den[DSW-1];
        end
    end

    // Range check: a quotient beyond the bits kept is marked as overflow.
    logic [DMW-1:0] r0;
    logic [DMW-1:0] rem_b_reg, dmag_b_reg;
    logic [QB-1:0]  nlo_b_reg;
    logic           neg_b_reg, ovf_b_reg;

    assign r0 = DMW'(nmag_reg[NMW-1:QB]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_b_reg  <= r0;
            ovf_b_reg  <= (r0 >= dmag_a_reg);
            nlo_b_reg  <= nmag_reg[QB-1:0];
            dmag_b_reg <= dmag_a_reg;
            neg_b_reg  <= neg_a_reg;
        end
    end

    // One quotient bit per stage.
    logic [DMW-1:0] rem_reg  [QB];
    logic [DMW-1:0] dm_reg   [QB];
    logic [QB-1:0]  q_reg    [QB];
    logic [QB-1:0]  nlo_reg  [QB];
    logic           neg_reg  [QB];
    logic           ovf_reg  [QB];

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [DMW-1:0] rem_p, dm_p;
        logic [QB-1:0]  q_p, nlo_p;
        logic           neg_p, ovf_p;
        logic [DMW:0]   trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign rem_p = rem_b_reg;
            assign dm_p  = dmag_b_reg;
            assign q_p   = '0;
            assign nlo_p = nlo_b_reg;
            assign neg_p = neg_b_reg;
            assign ovf_p = ovf_b_reg;
        end
        else
        begin : g_next
            assign rem_p = rem_reg[k-1];
            assign dm_p  = dm_reg[k-1];
            assign q_p   = q_reg[k-1];
            assign nlo_p = nlo_reg[k-1];
            assign neg_p = neg_reg[k-1];
            assign ovf_p = ovf_reg[k-1];
        end

        assign trial = {rem_p, nlo_p[QB-1]};
        assign ge    = (trial >= {1'b0, dm_p});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? DMW'(trial - {1'b0, dm_p}) : DMW'(trial);
                q_reg[k]   <= {q_p[QB-2:0], ge};
                nlo_reg[k] <= {nlo_p[QB-2:0], 1'b0};
                dm_reg[k]  <= dm_p;
                neg_reg[k] <= neg_p;
                ovf_reg[k] <= ovf_p;
            end
        end
    end

    // Rounding, ties away from zero, then the sign is applied.
    logic          rnd;
    logic [QB:0]   mag;

    assign rnd = ({rem_reg[QB-1], 1'b0} >= {1'b0, dm_reg[QB-1]});
    assign mag = ovf_reg[QB-1] ? {1'b1, QB'(0)} : ({1'b0, q_reg[QB-1]} + (QB+1)'(rnd));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot <= neg_reg[QB-1] ? $signed(RW'(0) - {1'b0, mag}) : $signed({1'b0, mag});
        end
    end

endmodule

/* rtl/tcc_sqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on nothing beyond its ports.
module tcc_sqrt #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic [2*COORD_WIDTH:0]   radicand,
    output logic [COORD_WIDTH:0]     root,
    output logic [COORD_WIDTH+1:0]   rem
);

    localparam int W   = COORD_WIDTH;
    localparam int NP  = 2 * W + 2;
    localparam int RTW = W + 1;
    localparam int RMW = W + 2;
    localparam int ST  = W + 1;

    logic [RMW-1:0] rem_reg  [ST];
    logic [RTW-1:0] root_reg [ST];
    logic [NP-1:0]  nr_reg   [ST];

    for (genvar k = 0; k < ST; k++)
    begin : g_step
        logic [RMW-1:0] rem_p;
        logic [RTW-1:0] root_p;
        logic [NP-1:0]  nr_p;
        logic [RMW+1:0] acc;
        logic [RMW:0]   trial;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign nr_p   = {1'b0, radicand};
        end
        else
        begin : g_next
            assign rem_p  = rem_reg[k-1];
            assign root_p = root_reg[k-1];
            assign nr_p   = nr_reg[k-1];
        end

        // Bring down two radicand bits and try the next root bit.
        assign acc   = {rem_p, nr_p[NP-1:NP-2]};
        assign trial = {root_p, 2'b01};
        assign ge    = (acc >= {1'b0, trial});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? RMW'(acc - {1'b0, trial}) : RMW'(acc);
                root_reg[k] <= {root_p[RTW-2:0], ge};
                nr_reg[k]   <= {nr_p[NP-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[ST-1];
    assign rem  = rem_reg[ST-1];

endmodule
